>>> hw/rtl/ctt_pkg.sv
// Shared types, codes and character constants for the config text tokenizer.
package ctt_pkg;

  // Lexer phases; code 7 is unused and behaves as skipping blanks
  typedef enum logic [2:0] {
    PH_SKIP       = 3'd0,
    PH_COMMENT    = 3'd1,
    PH_BARE       = 3'd2,
    PH_BARE_ESC   = 3'd3,
    PH_QUOTE      = 3'd4,
    PH_QUOTE_ESC  = 3'd5,
    PH_QUOTE_DROP = 3'd6
  } lex_phase_t;

  // Grammar phases; code 3 is unused and behaves as expecting item
  typedef enum logic [1:0] {
    GR_ITEM       = 2'd0,
    GR_AFTER_ITEM = 2'd1,
    GR_VALUE      = 2'd2
  } gram_phase_t;

  // Result event codes
  localparam logic [1:0] EV_CHAR   = 2'd0;
  localparam logic [1:0] EV_END    = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  // Error codes
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_EOT_IN_QUOTE  = 4'd1;
  localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd2;
  localparam logic [3:0] ERR_NL_IN_QUOTE   = 4'd3;
  localparam logic [3:0] ERR_QUOTE_LONG    = 4'd4;
  localparam logic [3:0] ERR_BSLASH_AT_EOT = 4'd5;
  localparam logic [3:0] ERR_TOKEN_LONG    = 4'd6;
  localparam logic [3:0] ERR_EQ_AS_ITEM    = 4'd7;
  localparam logic [3:0] ERR_VALUE_MISSING = 4'd8;
  localparam logic [3:0] ERR_EQ_AS_VALUE   = 4'd9;

  // Characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;

  localparam logic [7:0]  MAX_LEN_RESET = 8'd200;
  localparam logic [15:0] LINE_MAX      = 16'hFFFF;

  // Result queue geometry
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  // One result beat
  typedef struct packed {
    logic [7:0]  token_char;
    logic [1:0]  event_res;
    logic        token_role;
    logic        was_quoted;
    logic [3:0]  error_code;
    logic [15:0] line_number;
    logic        last_of_run;
  } res_t;

  // All results caused by one input beat
  typedef struct packed {
    logic [1:0]            count;
    res_t [MAX_RESULTS-1:0] res;
  } step_t;

  // Build a result beat from the lexer state at the time it is raised
  function automatic res_t make_res(logic [7:0] ch, logic [1:0] ev, logic [3:0] err,
                                    gram_phase_t gr, lex_phase_t ph, logic [15:0] line);
    res_t r;
    logic tok;
    tok = (ev == EV_CHAR) || (ev == EV_END);
    r.token_char  = tok ? ch : 8'd0;
    r.event_res   = ev;
    r.token_role  = tok && (gr == GR_VALUE);
    r.was_quoted  = tok && ((ph == PH_QUOTE) || (ph == PH_QUOTE_ESC) ||
                            (ph == PH_QUOTE_DROP));
    r.error_code  = err;
    r.line_number = line;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

>>> hw/rtl/ctt_stream_if.sv
// Valid/ready channel interfaces for the tokenizer's byte input and result output.
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  token_char;
  logic [1:0]  event_res;
  logic        token_role;
  logic        was_quoted;
  logic [3:0]  error_code;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (output valid, output token_char, output event_res, output token_role,
                  output was_quoted, output error_code, output line_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_char, input event_res, input token_role,
                  input was_quoted, input error_code, input line_number,
                  input last_of_run, output ready);
endinterface

>>> hw/rtl/ctt_lexer.sv
// Lexer and grammar state with the per-byte step that yields up to three results.
module ctt_lexer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  logic [7:0]    max_len,
  output ctt_pkg::step_t step
);

  ctt_pkg::lex_phase_t  ph_r, ph_nxt;
  ctt_pkg::gram_phase_t gr_r, gr_nxt;
  logic [7:0]           cc_r, cc_nxt;
  logic [15:0]          lc_r, lc_nxt;
  logic                 halt_r, halt_nxt;

  // One byte step: at most two passes (a token end re-handles its delimiter, a bare
  // token start re-handles its first byte, a dropped indent re-handles the byte in the quote)
  always_comb begin
    ctt_pkg::lex_phase_t  ph;
    ctt_pkg::gram_phase_t gr;
    logic [7:0]           cc;
    logic [15:0]          lc;
    logic                 halt;
    logic                 redo;
    logic [1:0]           n;
    ctt_pkg::res_t        ea, eb;
    logic                 ea_v, eb_v;
    logic                 eot;
    logic [7:0]           c;
    logic                 blank;

    ph   = ph_r;
    gr   = gr_r;
    cc   = cc_r;
    lc   = lc_r;
    halt = halt_r;
    redo = 1'b1;
    n    = 2'd0;
    eot  = end_of_text;
    c    = text_byte;
    blank = !eot && (c == ctt_pkg::CH_SPACE || c == ctt_pkg::CH_TAB);
    step = '0;

    for (int p = 0; p < 2; p++) begin
      ea   = '0;
      eb   = '0;
      ea_v = 1'b0;
      eb_v = 1'b0;
      if (redo && !halt) begin
        redo = 1'b0;
        case (ph)
          ctt_pkg::PH_COMMENT: begin
            if (!eot && c == ctt_pkg::CH_NL) begin
              if (lc != ctt_pkg::LINE_MAX) lc = lc + 16'd1;
              ph = ctt_pkg::PH_SKIP;
            end else if (eot) begin
              ea_v = 1'b1;
              if (gr == ctt_pkg::GR_VALUE) begin
                ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                         ctt_pkg::ERR_VALUE_MISSING, gr, ph, lc);
                halt = 1'b1;
              end else begin
                ea = ctt_pkg::make_res(8'd0, ctt_pkg::EV_FINISH, ctt_pkg::ERR_NONE,
                                       gr, ph, lc);
              end
            end
          end
          ctt_pkg::PH_BARE: begin
            if (cc >= max_len) begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR, ctt_pkg::ERR_TOKEN_LONG,
                                       gr, ph, lc);
              ea_v = 1'b1;
              halt = 1'b1;
            end else if (eot || blank || c == ctt_pkg::CH_NL || c == ctt_pkg::CH_HASH ||
                         c == ctt_pkg::CH_EQ) begin
              // token end, then the delimiter is handled between tokens
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_END, ctt_pkg::ERR_NONE,
                                       gr, ph, lc);
              ea_v = 1'b1;
              gr   = (gr == ctt_pkg::GR_VALUE) ? ctt_pkg::GR_ITEM : ctt_pkg::GR_AFTER_ITEM;
              ph   = ctt_pkg::PH_SKIP;
              redo = 1'b1;
            end else if (c == ctt_pkg::CH_BSLASH) begin
              ph = ctt_pkg::PH_BARE_ESC;
            end else begin
              ea   = ctt_pkg::make_res(c, ctt_pkg::EV_CHAR, ctt_pkg::ERR_NONE, gr, ph, lc);
              ea_v = 1'b1;
              cc   = cc + 8'd1;
            end
          end
          ctt_pkg::PH_BARE_ESC: begin
            if (cc >= max_len) begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR, ctt_pkg::ERR_TOKEN_LONG,
                                       gr, ph, lc);
              ea_v = 1'b1;
              halt = 1'b1;
            end else if (eot) begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                       ctt_pkg::ERR_BSLASH_AT_EOT, gr, ph, lc);
              ea_v = 1'b1;
              halt = 1'b1;
            end else begin
              ph = ctt_pkg::PH_BARE;
              if (c == ctt_pkg::CH_NL) begin
                if (lc != ctt_pkg::LINE_MAX) lc = lc + 16'd1;
              end else begin
                ea   = ctt_pkg::make_res((c == ctt_pkg::CH_TAB) ? ctt_pkg::CH_SPACE : c,
                                         ctt_pkg::EV_CHAR, ctt_pkg::ERR_NONE, gr, ph, lc);
                ea_v = 1'b1;
                cc   = cc + 8'd1;
              end
            end
          end
          ctt_pkg::PH_QUOTE: begin
            if (eot) begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                       ctt_pkg::ERR_EOT_IN_QUOTE, gr, ph, lc);
              ea_v = 1'b1;
              halt = 1'b1;
            end else if (c == ctt_pkg::CH_QUOTE) begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_END, ctt_pkg::ERR_NONE,
                                       gr, ph, lc);
              ea_v = 1'b1;
              gr   = (gr == ctt_pkg::GR_VALUE) ? ctt_pkg::GR_ITEM : ctt_pkg::GR_AFTER_ITEM;
              ph   = ctt_pkg::PH_SKIP;
            end else if (c == ctt_pkg::CH_BSLASH) begin
              ph = ctt_pkg::PH_QUOTE_ESC;
            end else if (c == ctt_pkg::CH_NL) begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                       ctt_pkg::ERR_NL_IN_QUOTE, gr, ph, lc);
              ea_v = 1'b1;
              halt = 1'b1;
            end else begin
              ea   = ctt_pkg::make_res(c, ctt_pkg::EV_CHAR, ctt_pkg::ERR_NONE, gr, ph, lc);
              ea_v = 1'b1;
              cc   = cc + 8'd1;
              if (cc >= max_len) begin
                eb   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                         ctt_pkg::ERR_QUOTE_LONG, gr, ph, lc);
                eb_v = 1'b1;
                halt = 1'b1;
              end
            end
          end
          ctt_pkg::PH_QUOTE_ESC: begin
            if (!eot && (c == ctt_pkg::CH_QUOTE || c == ctt_pkg::CH_BSLASH ||
                         c == ctt_pkg::CH_LOWER_N)) begin
              ph   = ctt_pkg::PH_QUOTE;
              ea   = ctt_pkg::make_res((c == ctt_pkg::CH_LOWER_N) ? ctt_pkg::CH_NL : c,
                                       ctt_pkg::EV_CHAR, ctt_pkg::ERR_NONE, gr, ph, lc);
              ea_v = 1'b1;
              cc   = cc + 8'd1;
              if (cc >= max_len) begin
                eb   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                         ctt_pkg::ERR_QUOTE_LONG, gr, ph, lc);
                eb_v = 1'b1;
                halt = 1'b1;
              end
            end else if (!eot && c == ctt_pkg::CH_NL) begin
              ph = ctt_pkg::PH_QUOTE_DROP;
            end else begin
              ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR, ctt_pkg::ERR_BAD_ESCAPE,
                                       gr, ph, lc);
              ea_v = 1'b1;
              halt = 1'b1;
            end
          end
          ctt_pkg::PH_QUOTE_DROP: begin
            // drop indentation after a continued line; a NUL is swallowed
            if (!blank) begin
              ph = ctt_pkg::PH_QUOTE;
              if (eot || c != ctt_pkg::CH_NUL) begin
                ea   = ctt_pkg::make_res(ctt_pkg::CH_SPACE, ctt_pkg::EV_CHAR,
                                         ctt_pkg::ERR_NONE, gr, ph, lc);
                ea_v = 1'b1;
                cc   = cc + 8'd1;
                if (cc >= max_len) begin
                  eb   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                           ctt_pkg::ERR_QUOTE_LONG, gr, ph, lc);
                  eb_v = 1'b1;
                  halt = 1'b1;
                end
                redo = 1'b1;
              end
            end
          end
          default: begin
            // between tokens
            ph = ctt_pkg::PH_SKIP;
            if (blank) begin
              // nothing
            end else if (!eot && c == ctt_pkg::CH_NL) begin
              if (lc != ctt_pkg::LINE_MAX) lc = lc + 16'd1;
            end else if (eot) begin
              ea_v = 1'b1;
              if (gr == ctt_pkg::GR_VALUE) begin
                ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                         ctt_pkg::ERR_VALUE_MISSING, gr, ph, lc);
                halt = 1'b1;
              end else begin
                ea = ctt_pkg::make_res(8'd0, ctt_pkg::EV_FINISH, ctt_pkg::ERR_NONE,
                                       gr, ph, lc);
              end
            end else if (c == ctt_pkg::CH_HASH) begin
              ph = ctt_pkg::PH_COMMENT;
            end else if (c == ctt_pkg::CH_EQ) begin
              if (gr == ctt_pkg::GR_AFTER_ITEM) begin
                gr = ctt_pkg::GR_VALUE;
              end else begin
                ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                         (gr == ctt_pkg::GR_VALUE) ?
                                         ctt_pkg::ERR_EQ_AS_VALUE : ctt_pkg::ERR_EQ_AS_ITEM,
                                         gr, ph, lc);
                ea_v = 1'b1;
                halt = 1'b1;
              end
            end else if (c == ctt_pkg::CH_QUOTE) begin
              ph = ctt_pkg::PH_QUOTE;
              cc = 8'd0;
              if (max_len == 8'd0) begin
                ea   = ctt_pkg::make_res(8'd0, ctt_pkg::EV_ERROR,
                                         ctt_pkg::ERR_QUOTE_LONG, gr, ph, lc);
                ea_v = 1'b1;
                halt = 1'b1;
              end
            end else begin
              ph   = ctt_pkg::PH_BARE;
              cc   = 8'd0;
              redo = 1'b1;
            end
          end
        endcase
      end
      // append this pass's results
      if (ea_v && n < 2'd3) begin
        step.res[n] = ea;
        n = n + 2'd1;
      end
      if (eb_v && n < 2'd3) begin
        step.res[n] = eb;
        n = n + 2'd1;
      end
    end

    if (n != 2'd0) step.res[n - 2'd1].last_of_run = 1'b1;
    step.count = n;

    // end of text always returns to the reset state
    if (eot) begin
      ph   = ctt_pkg::PH_SKIP;
      gr   = ctt_pkg::GR_ITEM;
      cc   = 8'd0;
      lc   = 16'd0;
      halt = 1'b0;
    end
    ph_nxt   = ph;
    gr_nxt   = gr;
    cc_nxt   = cc;
    lc_nxt   = lc;
    halt_nxt = halt;
  end

  // State registers, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= ctt_pkg::PH_SKIP;
      gr_r   <= ctt_pkg::GR_ITEM;
      cc_r   <= 8'd0;
      lc_r   <= 16'd0;
      halt_r <= 1'b0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      gr_r   <= gr_nxt;
      cc_r   <= cc_nxt;
      lc_r   <= lc_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

>>> hw/rtl/config_text_tokenizer.sv
// Top level: tokenizer state, length register and the result queue.
// Takes one text beat per cycle while ready. Each input beat is handled in the
// cycle it is accepted and yields zero to three result beats, which enter a
// four-entry queue drained one beat per cycle while the receiver is ready.
// The input is ready while at most one result beat is queued, so a stream whose
// bytes give at most one result each runs at one beat per cycle; a byte that
// gives two or three results (a token end followed by an end-of-text or error
// report, a quoted character or indent space followed by an overflow error, or
// an indent space followed by the re-handled byte's results) holds the input
// until the queue is back to one beat. There is no clearing pass after reset.
module config_text_tokenizer (
  input  logic            clk,
  input  logic            rst_n,
  ctt_in_if.sink          in_if,
  ctt_out_if.source       out_if,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);

  logic [7:0]               max_len_r;
  ctt_pkg::step_t           step;
  logic                     in_fire;
  logic                     pop;
  logic [1:0]               push_n;
  ctt_pkg::res_t            q_mem [ctt_pkg::FIFO_DEPTH];
  logic [ctt_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ctt_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;
  ctt_pkg::res_t            head;

  // Token length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ctt_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  ctt_lexer u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .text_byte   (in_if.text_byte),
    .end_of_text (in_if.end_of_text),
    .max_len     (max_len_r),
    .step        (step)
  );

  // Handshakes: room for a full set of results before taking a beat
  assign in_if.ready = (cnt_r <= ctt_pkg::FIFO_CW'(1));
  assign in_fire     = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;
  assign push_n      = in_fire ? step.count : 2'd0;
  assign cnt_nxt     = cnt_r + ctt_pkg::FIFO_CW'(push_n) - ctt_pkg::FIFO_CW'(pop);

  // Queue storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < ctt_pkg::MAX_RESULTS; k++) begin
      if (k < int'(push_n)) begin
        q_mem[wr_ptr_r + ctt_pkg::FIFO_AW'(k)] <= step.res[k];
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ctt_pkg::FIFO_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + ctt_pkg::FIFO_AW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  // Output beat from the queue head
  assign head               = q_mem[rd_ptr_r];
  assign out_if.valid       = (cnt_r != '0);
  assign out_if.token_char  = head.token_char;
  assign out_if.event_res   = head.event_res;
  assign out_if.token_role  = head.token_role;
  assign out_if.was_quoted  = head.was_quoted;
  assign out_if.error_code  = head.error_code;
  assign out_if.line_number = head.line_number;
  assign out_if.last_of_run = head.last_of_run;

  // Finish and error reports always close the results of their byte
  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.event_res == ctt_pkg::EV_FINISH ||
                      out_if.event_res == ctt_pkg::EV_ERROR)) |-> out_if.last_of_run)
    else $error("finish or error beat not marked last");

  // Role and quote marks only on token beats
  a_marks_on_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.event_res == ctt_pkg::EV_FINISH ||
                      out_if.event_res == ctt_pkg::EV_ERROR)) |->
    (!out_if.token_role && !out_if.was_quoted && out_if.token_char == 8'd0))
    else $error("token marks set on a non-token beat");

  // A pop with no push frees exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == 2'd0) |=> (cnt_r == $past(cnt_r) - ctt_pkg::FIFO_CW'(1)))
    else $error("queue count wrong after pop");

  // Queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (cnt_r + ctt_pkg::FIFO_CW'(step.count) <= ctt_pkg::FIFO_CW'(4)))
    else $error("result queue overflow");

endmodule
